@@ rtl/assert_macros.svh @@
// Assertion macros for the hover animation table controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`endif

@@ rtl/hat_pkg.sv @@
// Package for the hover animation table: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hat_pkg;
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_HOVER = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;
  localparam logic [1:0] REG_MAX_FRAME = 2'd0;
  localparam logic [1:0] REG_RISE  = 2'd1;
  localparam logic [1:0] REG_FALL  = 2'd2;
  localparam logic [1:0] REG_SWEEP = 2'd3;
  localparam logic [31:0] KEY_SCRAMBLE = 32'h9E3779B9;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // channel words
  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] frame_time;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        is_hovered;
  } hat_in_t;

  typedef struct packed {
    logic [16:0] anim_value;
    logic        stateless_fallback;
  } hat_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_TICK_CLR, ST_SCAN, ST_DECIDE, ST_UPDATE,
    ST_EASE1, ST_EASE2, ST_EASE3, ST_SWEEP, ST_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic inc_start;  // start increment computation
    logic inc_step;   // one increment multiply
    logic clr_step;   // clear flags of scan index
    logic scan_start;
    logic scan_step;
    logic hov_update;
    logic ease1;
    logic ease2;
    logic ease3;
    logic sweep_update;
    logic out_load;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] command;
    logic       scan_last;
    logic       inc_last;
    logic       hit;
    logic       hovered;
    logic       alloc_ok;
    logic       drop_result;  // miss while not hovered, freed, or full: no ease
  } status_t;
endpackage
`default_nettype wire

@@ rtl/hat_if.sv @@
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface hat_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/hat_ctrl.sv @@
// Controller state machine for the hover animation table.
// Depends on hat_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hat_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire hat_pkg::status_t sts,
  output hat_pkg::cmd_t        cmd
);
  hat_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hat_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hat_pkg::ST_IDLE: begin
        if (in_valid && in_ready) state_next = hat_pkg::ST_TICK;
      end
      hat_pkg::ST_TICK: begin
        case (sts.command)
          hat_pkg::CMD_TICK: state_next = hat_pkg::ST_TICK_CLR;
          hat_pkg::CMD_HOVER, hat_pkg::CMD_SWEEP: state_next = hat_pkg::ST_SCAN;
          default: state_next = hat_pkg::ST_IDLE;
        endcase
      end
      hat_pkg::ST_TICK_CLR: begin
        if (sts.scan_last && sts.inc_last) state_next = hat_pkg::ST_IDLE;
      end
      hat_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = hat_pkg::ST_DECIDE;
      end
      hat_pkg::ST_DECIDE: begin
        if (sts.command == hat_pkg::CMD_SWEEP) state_next = hat_pkg::ST_SWEEP;
        else state_next = hat_pkg::ST_UPDATE;
      end
      hat_pkg::ST_UPDATE: begin
        if (sts.drop_result) state_next = hat_pkg::ST_OUT;
        else state_next = hat_pkg::ST_EASE1;
      end
      hat_pkg::ST_EASE1: state_next = hat_pkg::ST_EASE2;
      hat_pkg::ST_EASE2: state_next = hat_pkg::ST_EASE3;
      hat_pkg::ST_EASE3: state_next = hat_pkg::ST_OUT;
      hat_pkg::ST_SWEEP: state_next = hat_pkg::ST_OUT;
      hat_pkg::ST_OUT: begin
        if (!out_valid || out_ready) state_next = hat_pkg::ST_IDLE;
      end
      default: state_next = hat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      hat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      hat_pkg::ST_TICK: begin
        cmd.inc_start = 1'b1;
        cmd.scan_start = 1'b1;
      end
      hat_pkg::ST_TICK_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.inc_step = 1'b1;
      end
      hat_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      hat_pkg::ST_UPDATE: cmd.hov_update = 1'b1;
      hat_pkg::ST_EASE1: cmd.ease1 = 1'b1;
      hat_pkg::ST_EASE2: cmd.ease2 = 1'b1;
      hat_pkg::ST_EASE3: cmd.ease3 = 1'b1;
      hat_pkg::ST_SWEEP: cmd.sweep_update = 1'b1;
      hat_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == hat_pkg::ST_IDLE)
  `ASSERT_NEXT(a_out_load, clk, rst, cmd.out_load, out_valid)
  `ASSERT_IMP(a_one_step, clk, rst, cmd.scan_step, !cmd.clr_step)
endmodule
`default_nettype wire

@@ rtl/hat_datapath.sv @@
// Datapath: entry stores, key search, progress update, ease-out and increments.
// Depends on hat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hat_datapath #(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire hat_pkg::cmd_t cmd,
  output hat_pkg::status_t sts,
  input  wire logic [1:0]  command,
  input  wire logic [19:0] frame_time,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic        is_hovered,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic [16:0]      anim_value,
  output logic             stateless_fallback
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0] LAST = (IW+1)'(ENTRIES - 1);

  logic [19:0] max_frame_time;
  logic [23:0] rise_rate, fall_rate, sweep_rate;
  logic [16:0] rise_inc, fall_inc, sweep_inc;

  logic [31:0] key_r [ENTRIES];
  logic [ENTRIES-1:0] kvalid, seen, swadv, prevh;
  logic [16:0] hprog [ENTRIES];
  logic [16:0] sprog [ENTRIES];

  logic [1:0]  cmd_r;
  logic [19:0] dt;
  logic [31:0] key;
  logic        hov;
  logic [IW-1:0] idx, idx_q;
  logic          idx_end;
  logic          cmp_v;
  logic [31:0]   key_q;
  logic [16:0]   hp_q, sp_q;
  logic [1:0]    inc_cnt;
  logic          hit, free_found, unseen_found;
  logic [IW-1:0] hit_idx, free_idx, unseen_idx, ent;
  logic [16:0]   p_new, u;
  logic [33:0]   sq;
  logic [50:0]   cube;
  logic [16:0]   result;
  logic          fallback;
  logic          drop_pre;
  logic          sweep_adv;
  logic [17:0]   sweep_raw;
  logic [16:0]   sweep_sum;
  logic [43:0]   prod;
  logic [23:0]   rate_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_time <= 20'd50000;
      rise_rate <= 24'd35791;
      fall_rate <= 24'd23861;
      sweep_rate <= 24'd14317;
    end else if (cfg_write) begin
      case (cfg_index)
        hat_pkg::REG_MAX_FRAME: max_frame_time <= cfg_data[19:0];
        hat_pkg::REG_RISE: rise_rate <= cfg_data;
        hat_pkg::REG_FALL: fall_rate <= cfg_data;
        hat_pkg::REG_SWEEP: sweep_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture word, form key and clamp time
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      logic [31:0] k;
      k = {pos_x, pos_y} ^ hat_pkg::KEY_SCRAMBLE;
      cmd_r <= command;
      key <= (k == 32'd0) ? 32'd1 : k;
      hov <= is_hovered;
      dt <= (frame_time > max_frame_time) ? max_frame_time : frame_time;
    end
  end

  always_comb begin
    case (inc_cnt)
      2'd0: rate_sel = rise_rate;
      2'd1: rate_sel = fall_rate;
      default: rate_sel = sweep_rate;
    endcase
  end
  assign prod = {24'd0, dt} * {20'd0, rate_sel};

  // one increment per cycle during the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_inc <= '0; fall_inc <= '0; sweep_inc <= '0;
      inc_cnt <= '0;
    end else if (cmd.inc_start) begin
      inc_cnt <= '0;
    end else if (cmd.inc_step && inc_cnt != 2'd3) begin
      logic [16:0] v;
      v = (prod[43:16] > 28'h10000) ? hat_pkg::ONE_Q16 : prod[32:16];
      case (inc_cnt)
        2'd0: rise_inc <= v;
        2'd1: fall_inc <= v;
        default: sweep_inc <= v;
      endcase
      inc_cnt <= inc_cnt + 2'd1;
    end
  end

  // scan index sweep
  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.load) begin
      idx <= '0;
      idx_end <= 1'b0;
    end else if ((cmd.scan_step || cmd.clr_step) && !idx_end) begin
      if ({1'b0, idx} == LAST) idx_end <= 1'b1;
      else idx <= idx + IW'(1);
    end
  end

  // search in the cycle after the key read address: first hit, first free, first unseen
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      hit <= 1'b0; free_found <= 1'b0; unseen_found <= 1'b0;
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= cmd.scan_step && !idx_end;
      idx_q <= idx;
      if (cmp_v) begin
        if (!hit && kvalid[idx_q] && key_q == key) begin
          hit <= 1'b1; hit_idx <= idx_q;
        end
        if (!free_found && !kvalid[idx_q]) begin
          free_found <= 1'b1; free_idx <= idx_q;
        end
        if (!unseen_found && !seen[idx_q]) begin
          unseen_found <= 1'b1; unseen_idx <= idx_q;
        end
      end
    end
  end

  assign ent = hit ? hit_idx : (free_found ? free_idx : unseen_idx);
  assign drop_pre = !hit && (!hov || (!free_found && !unseen_found));

  always_comb begin
    logic [16:0] p0;
    logic [17:0] s;
    p0 = hit ? hp_q : 17'd0;
    s = {1'b0, p0} + {1'b0, rise_inc};
    if (hov) begin
      p_new = (s > 18'h10000) ? hat_pkg::ONE_Q16 : s[16:0];
    end else begin
      p_new = (p0 > fall_inc) ? p0 - fall_inc : 17'd0;
    end
  end

  assign sweep_adv = hit && (sp_q < hat_pkg::ONE_Q16) && !swadv[ent];
  assign sweep_raw = {1'b0, sp_q} + {1'b0, sweep_inc};
  assign sweep_sum = (sweep_raw > 18'h10000) ? hat_pkg::ONE_Q16 : sweep_raw[16:0];

  // entry flags; a cleared valid bit marks a free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
      seen <= '0;
      swadv <= '0;
    end else if (cmd.clr_step && !idx_end) begin
      seen[idx] <= 1'b0;
      swadv[idx] <= 1'b0;
    end else if (cmd.hov_update && !drop_pre) begin
      if (!hit) swadv[ent] <= 1'b1;
      seen[ent] <= 1'b1;
      kvalid[ent] <= hov || (p_new != 17'd0);
    end else if (cmd.sweep_update && sweep_adv) begin
      swadv[ent] <= 1'b1;
    end
  end

  // key store with registered read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.hov_update && !drop_pre && !hit) key_r[ent] <= key;
    key_q <= key_r[idx];
  end

  // progress stores with registered read at the chosen entry
  always_ff @(posedge clk) begin
    if (cmd.hov_update && !drop_pre) begin
      hprog[ent] <= p_new;
      prevh[ent] <= hov;
      if (hov && (!hit || !prevh[ent])) sprog[ent] <= 17'd0;
      else if (!hit) sprog[ent] <= hat_pkg::ONE_Q16;
    end else if (cmd.sweep_update && sweep_adv) begin
      sprog[ent] <= sweep_sum;
    end
    hp_q <= hprog[ent];
    sp_q <= sprog[ent];
  end

  // result and ease-out pipeline: one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.hov_update) begin
      fallback <= 1'b0;
      u <= hat_pkg::ONE_Q16 - p_new;
      if (!hit && !hov) result <= 17'd0;
      else if (!hit && !free_found && !unseen_found) begin
        result <= hat_pkg::ONE_Q16; fallback <= 1'b1;
      end else if (!hov && p_new == 17'd0) result <= 17'd0;
    end else if (cmd.ease1) begin
      sq <= {17'd0, u} * {17'd0, u};
    end else if (cmd.ease2) begin
      cube <= {17'd0, sq} * {34'd0, u};
    end else if (cmd.ease3) begin
      logic [51:0] r;
      r = {1'b0, cube} + 52'h80000000;
      result <= hat_pkg::ONE_Q16 - r[48:32];
    end else if (cmd.sweep_update) begin
      fallback <= 1'b0;
      result <= !hit ? hat_pkg::ONE_Q16 : (sweep_adv ? sweep_sum : sp_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      anim_value <= result;
      stateless_fallback <= fallback;
    end
  end

  assign sts.command = cmd_r;
  assign sts.scan_last = idx_end;
  assign sts.inc_last = (inc_cnt == 2'd3);
  assign sts.hit = hit;
  assign sts.hovered = hov;
  assign sts.alloc_ok = free_found || unseen_found;
  assign sts.drop_result = drop_pre || (!hov && p_new == 17'd0);
endmodule
`default_nettype wire

@@ rtl/hover_animation_table_core.sv @@
// Top level of the hover animation table: channel ports, controller, datapath.
// Hover query: key scan, entry update, then ease-out multiplies unless the result
// is dropped. Sweep query: key scan and sweep update, no ease-out. Tick: clears
// the entry flags and forms the increments, no result. Scan: one entry per cycle.
// One word in flight; the next is accepted once any result word is registered.
// Synchronous active-high reset frees all entries and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module hover_animation_table_core #(
  parameter int ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  hat_if.sink       in_ch,
  hat_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  hat_pkg::cmd_t    cmd;
  hat_pkg::status_t sts;

  hat_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  hat_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .command(in_ch.data.command), .frame_time(in_ch.data.frame_time),
    .pos_x(in_ch.data.pos_x), .pos_y(in_ch.data.pos_y),
    .is_hovered(in_ch.data.is_hovered),
    .cfg_write(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .anim_value(out_ch.data.anim_value),
    .stateless_fallback(out_ch.data.stateless_fallback)
  );
endmodule
`default_nettype wire

@@ sim/hat_tb_pkg.sv @@
// Testbench codes of the hover animation table: the unused command code.
// Depends on nothing.
`timescale 1ns / 1ps
package hat_tb_pkg;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
endpackage

@@ sim/hat_checker.sv @@
// Scoreboard for the hover animation table: tracks table state from accepted words
// and register writes, and compares every result word. Depends on hat_pkg.
`timescale 1ns / 1ps
module hat_checker #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  hat_pkg::hat_in_t  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  hat_pkg::hat_out_t out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);
  logic [19:0] max_frame;
  logic [23:0] rise_rate, fall_rate, sweep_rate;
  logic [31:0] key_store [ENTRIES];
  logic [16:0] hover_prog [ENTRIES];
  logic [16:0] sweep_prog [ENTRIES];
  logic        seen [ENTRIES];
  logic        last_hov [ENTRIES];
  logic        swept [ENTRIES];
  logic [16:0] rise_inc, fall_inc, sweep_inc;
  hat_pkg::hat_out_t anim_q [$];

  assign pending = anim_q.size();

  function automatic logic [16:0] scaled_inc(logic [19:0] dt, logic [23:0] rate);
    logic [63:0] v;
    v = (64'(dt) * 64'(rate)) >> 16;
    return (v > 64'(hat_pkg::ONE_Q16)) ? hat_pkg::ONE_Q16 : v[16:0];
  endfunction

  function automatic logic [16:0] ease_out(logic [16:0] p);
    logic [63:0] u, cube;
    u = 64'(hat_pkg::ONE_Q16) - 64'(p);
    cube = u * u * u;
    return hat_pkg::ONE_Q16 - 17'((cube + 64'h8000_0000) >> 32);
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (key_store[i] == key) return i;
    return -1;
  endfunction

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // advance the table by one accepted word and queue the result it causes
  task automatic apply_word(hat_pkg::hat_in_t w);
    logic [19:0] dt;
    logic [31:0] key;
    logic [16:0] p;
    logic [17:0] s;
    hat_pkg::hat_out_t r;
    int          e;
    r = '0;
    key = {w.pos_x, 16'h0} ^ {16'h0, w.pos_y} ^ hat_pkg::KEY_SCRAMBLE;
    if (key == 0) key = 1;
    case (w.command)
      hat_pkg::CMD_TICK: begin
        dt = (w.frame_time > max_frame) ? max_frame : w.frame_time;
        rise_inc = scaled_inc(dt, rise_rate);
        fall_inc = scaled_inc(dt, fall_rate);
        sweep_inc = scaled_inc(dt, sweep_rate);
        for (int i = 0; i < ENTRIES; i++) begin
          seen[i] = 0;
          swept[i] = 0;
        end
        return;
      end
      hat_pkg::CMD_HOVER: begin
        e = find_slot(key);
        if (e < 0) begin
          if (!w.is_hovered) begin
            anim_q.push_back(r);
            return;
          end
          e = find_slot(0);
          if (e < 0)
            for (int i = 0; i < ENTRIES; i++)
              if (!seen[i]) begin
                e = i;
                break;
              end
          if (e < 0) begin
            r.anim_value = hat_pkg::ONE_Q16;
            r.stateless_fallback = 1;
            anim_q.push_back(r);
            return;
          end
          key_store[e] = key;
          hover_prog[e] = 0;
          sweep_prog[e] = hat_pkg::ONE_Q16;
          last_hov[e] = 0;
          swept[e] = 1;
        end
        if (w.is_hovered && !last_hov[e]) sweep_prog[e] = 0;
        last_hov[e] = w.is_hovered;
        p = hover_prog[e];
        if (w.is_hovered) begin
          s = 18'(p) + 18'(rise_inc);
          p = (s > 18'(hat_pkg::ONE_Q16)) ? hat_pkg::ONE_Q16 : s[16:0];
        end else begin
          p = (p > fall_inc) ? p - fall_inc : 17'd0;
        end
        hover_prog[e] = p;
        seen[e] = 1;
        if (!w.is_hovered && p == 0) key_store[e] = 0;
        else r.anim_value = ease_out(p);
        anim_q.push_back(r);
      end
      hat_pkg::CMD_SWEEP: begin
        e = find_slot(key);
        if (e < 0) begin
          r.anim_value = hat_pkg::ONE_Q16;
        end else begin
          if (sweep_prog[e] < hat_pkg::ONE_Q16 && !swept[e]) begin
            s = 18'(sweep_prog[e]) + 18'(sweep_inc);
            sweep_prog[e] = (s > 18'(hat_pkg::ONE_Q16)) ? hat_pkg::ONE_Q16 : s[16:0];
            swept[e] = 1;
          end
          r.anim_value = sweep_prog[e];
        end
        anim_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    hat_pkg::hat_out_t want;
    if (rst) begin
      max_frame = 20'd50000;
      rise_rate = 24'd35791;
      fall_rate = 24'd23861;
      sweep_rate = 24'd14317;
      rise_inc = 0;
      fall_inc = 0;
      sweep_inc = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        key_store[i] = 0;
        hover_prog[i] = 0;
        sweep_prog[i] = 0;
        seen[i] = 0;
        last_hov[i] = 0;
        swept[i] = 0;
      end
    end else begin
      if (cfg_we)
        case (cfg_index)
          hat_pkg::REG_MAX_FRAME: max_frame = cfg_data[19:0];
          hat_pkg::REG_RISE:      rise_rate = cfg_data;
          hat_pkg::REG_FALL:      fall_rate = cfg_data;
          hat_pkg::REG_SWEEP:     sweep_rate = cfg_data;
          default: ;
        endcase
      if (out_valid && out_ready) begin
        if (anim_q.size() == 0) begin
          report("unexpected result word", out_data.anim_value, 17'd0);
        end else begin
          want = anim_q.pop_front();
          if (out_data.anim_value !== want.anim_value)
            report("anim_value", out_data.anim_value, want.anim_value);
          if (out_data.stateless_fallback !== want.stateless_fallback)
            report("stateless_fallback", 17'(out_data.stateless_fallback),
                   17'(want.stateless_fallback));
        end
      end
      if (in_valid && in_ready) apply_word(in_data);
    end
  end

  initial errors = 0;
endmodule

@@ sim/tb_top.sv @@
// Top of the hover animation table testbench: clock, reset, stimulus, verdict.
// Depends on hat_pkg, hat_if, hat_tb_pkg, hat_checker and the core.
`timescale 1ns / 1ps
module tb_top;
  localparam int ENTRIES = 64;
  localparam int POOL = 80;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int errors, pending;
  int idle_cycles = 0;
  bit gaps_on = 0;
  bit hold_req = 0;
  bit stim_done = 0;
  logic [15:0] pool_x [POOL];
  logic [15:0] pool_y [POOL];

  hat_if #(.T(hat_pkg::hat_in_t))  in_ch (clk);
  hat_if #(.T(hat_pkg::hat_out_t)) out_ch (clk);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  hover_animation_table_core #(.ENTRIES(ENTRIES)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hat_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    bit got;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
      end else begin
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
          out_ch.ready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1;
      got = 0;
      while (!got) begin
        @(negedge clk);
        got = out_ch.valid;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(hat_pkg::hat_in_t w);
    int gap;
    bit got;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    got = 0;
    while (!got) begin
      @(negedge clk);
      got = in_ch.ready;
    end
    @(posedge clk);
  endtask

  function automatic hat_pkg::hat_in_t mk(logic [1:0] c, logic [19:0] ft, logic [15:0] x,
                                          logic [15:0] y, logic h);
    hat_pkg::hat_in_t w;
    w.command = c;
    w.frame_time = ft;
    w.pos_x = x;
    w.pos_y = y;
    w.is_hovered = h;
    return w;
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 20'($urandom_range(0, 1000000));
      1: return 0;
      default: return 20'($urandom_range(0, 40000));
    endcase
  endfunction

  function automatic hat_pkg::hat_in_t pool_word(logic [1:0] c, int i, logic h);
    return mk(c, 20'($urandom_range(0, 1000000)), pool_x[i], pool_y[i], h);
  endfunction

  // drain results, then let a possible trailing tick finish before a write
  task automatic settle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_regs(logic [19:0] mf, logic [23:0] r, logic [23:0] f, logic [23:0] s);
    write_reg(hat_pkg::REG_MAX_FRAME, 24'(mf));
    write_reg(hat_pkg::REG_RISE, r);
    write_reg(hat_pkg::REG_FALL, f);
    write_reg(hat_pkg::REG_SWEEP, s);
  endtask

  task automatic random_phase(int n_items, bit pause_once);
    int sent, k, base, span, i;
    sent = 0;
    while (sent < n_items) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send(mk(hat_pkg::CMD_TICK, rand_dt(), 16'($urandom), 16'($urandom), 1'($urandom)));
      sent++;
      if ($urandom_range(0, 11) == 0) begin
        // hover many distinct widgets in one frame to fill the table
        for (i = 0; i < ENTRIES + 3; i++) send(pool_word(hat_pkg::CMD_HOVER, i, 1));
        sent += ENTRIES + 3;
        continue;
      end
      base = $urandom_range(0, POOL - 1);
      span = $urandom_range(1, 12);
      k = $urandom_range(1, 20);
      repeat (k) begin
        i = (base + $urandom_range(0, span - 1)) % POOL;
        case ($urandom_range(0, 19))
          0: send(mk(hat_tb_pkg::CMD_UNUSED, 20'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom)));
          1: send(mk(hat_pkg::CMD_HOVER, 20'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom)));
          2, 3, 4, 5, 6: send(pool_word(hat_pkg::CMD_SWEEP, i, 1'($urandom)));
          7, 8, 9, 10, 11: send(pool_word(hat_pkg::CMD_HOVER, i, 0));
          default: send(pool_word(hat_pkg::CMD_HOVER, i, 1));
        endcase
        sent++;
      end
      if (pause_once && sent > n_items / 2) begin
        pause_once = 0;
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      pool_x[i] = 16'($urandom);
      pool_y[i] = 16'($urandom);
    end
    // this position hashes to the zero key
    pool_x[3] = 16'h9E37;
    pool_y[3] = 16'h79B9;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 1));
    send(mk(hat_pkg::CMD_TICK, 0, 0, 0, 0));
    send(mk(hat_pkg::CMD_TICK, 20'd1000000, 16'hFFFF, 16'hFFFF, 1));
    send(mk(hat_pkg::CMD_HOVER, 20'hFFFFF & 20'd1000000, 16'h9E37, 16'h79B9, 1));
    send(mk(hat_pkg::CMD_SWEEP, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'hFFFF, 16'hFFFF, 1));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h0000, 16'h0000, 0));
    send(mk(hat_pkg::CMD_SWEEP, 0, 16'h1234, 16'h5678, 1));
    send(mk(hat_pkg::CMD_TICK, 20'd16000, 0, 0, 0));
    send(mk(hat_pkg::CMD_SWEEP, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_SWEEP, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'hFFFF, 16'hFFFF, 1));
    send(mk(hat_tb_pkg::CMD_UNUSED, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 1));
    send(mk(hat_pkg::CMD_TICK, 20'd50000, 0, 0, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 1));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'h9E37, 16'h79B9, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'hFFFF, 16'hFFFF, 0));
    send(mk(hat_pkg::CMD_HOVER, 0, 16'hFFFF, 16'hFFFF, 0));
    send(mk(hat_pkg::CMD_SWEEP, 0, 16'hFFFF, 16'hFFFF, 0));
    settle();

    random_phase(350, 1);
    settle();
    set_regs(20'd1000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    hold_req = 1;
    random_phase(350, 0);
    settle();
    set_regs(20'd0, 24'd0, 24'd0, 24'd0);
    random_phase(200, 0);
    settle();
    set_regs(20'($urandom_range(0, 1000000)), 24'($urandom), 24'($urandom),
             24'($urandom));
    random_phase(350, 0);
    settle();
    set_regs(20'd1000000, 24'($urandom_range(1, 4000)), 24'($urandom_range(1, 4000)),
             24'($urandom_range(1, 4000)));
    random_phase(400, 0);

    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
